// ===== hw/rtl/kndd_pkg.sv =====
// Shared types and constants of the keypad number duplicate detector.
// Depends on nothing; every other file of the block imports it.
package kndd_pkg;

	localparam int TOTAL_DIGITS_DEF = 7;
	localparam int QUEUE_DEPTH_DEF  = 2;
	localparam int SUB_W            = 20;
	localparam int CNT_W            = 4;
	localparam int REGION_SIZE      = 1000000;
	localparam int ROW_W            = 64;

	typedef enum logic [1:0] {
		ST_NEW = 2'd0,
		ST_DUP = 2'd1,
		ST_BAD = 2'd2
	} status_t;

	typedef struct packed {
		logic             bad;
		logic             lead_six;
		logic [SUB_W-1:0] subscriber;
	} num_rec_t;

endpackage

// ===== hw/rtl/keypad_number_duplicate_detector_top.sv =====
// Top level of the keypad number duplicate detector.
// Instantiates kndd_front, kndd_queue and kndd_back; uses kndd_pkg.
//
// Input channel (in_valid/in_ready): one character of a phone number per
// item in char_in, with last high on the final character of the number.
// Output channel (out_valid/out_ready): one result per number, given for
// the item with last high: status (new, duplicate, invalid), prefix_six
// and the six trailing digits in subscriber (both zero when invalid).
// Throughput: one character per cycle, one number per cycle at most,
// while in_ready is high. The record of a number enters the queue at
// the accepting edge, then passes the bitmap read stage and the result
// register; a stall on the result side holds it back.
// The bitmap is a 32768 x 64 memory with one read and
// one write port; a one-row forward covers back-to-back numbers that hit
// the same row.
// Reset: the bitmap is cleared one row a cycle, all 32768 rows, with
// in_ready low all that time.
// When the receiver stalls the result register holds, the bitmap stage
// and the record queue fill, and then in_ready drops.
module keypad_number_duplicate_detector_top #(
	parameter int TOTAL_DIGITS = kndd_pkg::TOTAL_DIGITS_DEF,
	parameter int QUEUE_DEPTH  = kndd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_in,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        prefix_six,
	output logic [19:0] subscriber
);
	import kndd_pkg::*;

	logic     push, q_full, q_valid, q_ready, clr_done;
	num_rec_t push_rec, q_rec;

	kndd_front #(
		.TOTAL_DIGITS(TOTAL_DIGITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.char_in  (char_in),
		.last     (last),
		.q_full   (q_full),
		.clr_done (clr_done),
		.push     (push),
		.push_rec (push_rec)
	);

	kndd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (q_full),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_rec    (q_rec)
	);

	kndd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_rec      (q_rec),
		.clr_done   (clr_done),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.prefix_six (prefix_six),
		.subscriber (subscriber)
	);

endmodule

// ===== hw/rtl/kndd_front.sv =====
// Front part: maps keypad characters to digits, accumulates one number
// and pushes a classified number record on its last character. Uses kndd_pkg.
module kndd_front #(
	parameter int TOTAL_DIGITS = kndd_pkg::TOTAL_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         char_in,
	input  logic               last,
	input  logic               q_full,
	input  logic               clr_done,
	output logic               push,
	output kndd_pkg::num_rec_t push_rec
);
	import kndd_pkg::*;

	typedef enum logic [1:0] {
		KP_DIGIT,
		KP_DASH,
		KP_BAD
	} kp_class_t;

	typedef struct packed {
		kp_class_t  cls;
		logic [3:0] val;
	} kp_t;

	function automatic kp_t kp_decode(input logic [7:0] c);
		kp_t r;
		r.cls = KP_DIGIT;
		r.val = 4'd0;
		if (c >= "0" && c <= "9") begin
			r.val = 4'(c - "0");
		end else if (c == "-") begin
			r.cls = KP_DASH;
		end else if (c >= "A" && c <= "C") begin
			r.val = 4'd2;
		end else if (c >= "D" && c <= "F") begin
			r.val = 4'd3;
		end else if (c >= "G" && c <= "I") begin
			r.val = 4'd4;
		end else if (c >= "J" && c <= "L") begin
			r.val = 4'd5;
		end else if (c >= "M" && c <= "O") begin
			r.val = 4'd6;
		end else if (c == "P" || c == "R" || c == "S") begin
			r.val = 4'd7;
		end else if (c >= "T" && c <= "V") begin
			r.val = 4'd8;
		end else if (c >= "W" && c <= "Y") begin
			r.val = 4'd9;
		end else begin
			r.cls = KP_BAD;
		end
		return r;
	endfunction

	localparam logic [CNT_W-1:0] TOTAL_CNT  = CNT_W'(TOTAL_DIGITS);
	localparam logic [SUB_W-1:0] REGION_LIM = SUB_W'(REGION_SIZE);

	logic [CNT_W-1:0] digit_count_q, cnt_n;
	logic [SUB_W-1:0] accum_q, accum_n;
	logic             lead_ok_q, lead_ok_n;
	logic             lead_six_q, lead_six_n;
	logic             bad_q, bad_n;
	logic             fire;
	logic             num_bad;
	kp_t              kp;

	assign kp       = kp_decode(char_in);
	assign in_ready = !q_full && clr_done;
	assign fire     = in_valid && in_ready;

	always_comb begin
		cnt_n      = digit_count_q;
		accum_n    = accum_q;
		lead_ok_n  = lead_ok_q;
		lead_six_n = lead_six_q;
		bad_n      = bad_q;
		case (kp.cls)
			KP_BAD: begin
				bad_n = 1'b1;
			end
			KP_DIGIT: begin
				if (digit_count_q == '0) begin
					lead_ok_n  = (kp.val == 4'd3) || (kp.val == 4'd6);
					lead_six_n = (kp.val == 4'd6);
				end else if (digit_count_q < TOTAL_CNT) begin
					accum_n = (accum_q << 3) + (accum_q << 1) + SUB_W'(kp.val);
				end
				if (digit_count_q <= TOTAL_CNT) begin
					cnt_n = digit_count_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign num_bad = bad_n || !lead_ok_n || (cnt_n != TOTAL_CNT) || (accum_n >= REGION_LIM);

	assign push                = fire && last;
	assign push_rec.bad        = num_bad;
	assign push_rec.lead_six   = num_bad ? 1'b0 : lead_six_n;
	assign push_rec.subscriber = num_bad ? '0 : accum_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= '0;
			accum_q       <= '0;
			lead_ok_q     <= 1'b0;
			lead_six_q    <= 1'b0;
			bad_q         <= 1'b0;
		end else if (fire) begin
			if (last) begin
				digit_count_q <= '0;
				accum_q       <= '0;
				lead_ok_q     <= 1'b0;
				lead_six_q    <= 1'b0;
				bad_q         <= 1'b0;
			end else begin
				digit_count_q <= cnt_n;
				accum_q       <= accum_n;
				lead_ok_q     <= lead_ok_n;
				lead_six_q    <= lead_six_n;
				bad_q         <= bad_n;
			end
		end
	end

endmodule

// ===== hw/rtl/kndd_queue.sv =====
// Short queue of number records between front and back parts.
// Uses kndd_pkg for the record type.
module kndd_queue #(
	parameter int DEPTH = kndd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  kndd_pkg::num_rec_t push_rec,
	output logic               full,
	output logic               q_valid,
	input  logic               q_ready,
	output kndd_pkg::num_rec_t q_rec
);
	import kndd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

	num_rec_t         slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OCC_W-1:0] occ_q;
	logic             pop;

	assign full    = (occ_q == FULL_OCC);
	assign q_valid = (occ_q != '0);
	assign q_rec   = slot_q[rd_ptr_q];
	assign pop     = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				occ_q <= occ_q + 1'b1;
			end else if (pop && !push) begin
				occ_q <= occ_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/kndd_back.sv =====
// Back part: seen-bitmap memory with its clearing pass, read-modify-write
// stage with forwarding, and the result register. Uses kndd_pkg.
module kndd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_ready,
	input  kndd_pkg::num_rec_t q_rec,
	output logic               clr_done,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic               prefix_six,
	output logic [19:0]        subscriber
);
	import kndd_pkg::*;

	localparam int IDX_W  = SUB_W + 1;
	localparam int BSEL_W = $clog2(ROW_W);
	localparam int RADR_W = IDX_W - BSEL_W;
	localparam int ROWS   = 2 ** RADR_W;
	localparam logic [RADR_W-1:0] LAST_ROW = RADR_W'(ROWS - 1);

	logic [ROW_W-1:0]  seen_mem [ROWS];

	logic              clr_busy_q;
	logic [RADR_W-1:0] clr_row_q;

	logic              s2_valid_q;
	num_rec_t          rec_s2;
	logic [ROW_W-1:0]  rdata_s2;
	logic              fwd_valid_q;
	logic [RADR_W-1:0] fwd_row_q;
	logic [ROW_W-1:0]  fwd_data_q;

	logic              out_valid_q;
	status_t           status_q;
	logic              prefix_q;
	logic [SUB_W-1:0]  sub_q;

	logic [IDX_W-1:0]  q_idx, s2_idx;
	logic [RADR_W-1:0] s2_row;
	logic [BSEL_W-1:0] s2_bit;
	logic [ROW_W-1:0]  old_row, new_row;
	logic              hit, s2_fire, s2_write, load;
	logic              mem_we;
	logic [RADR_W-1:0] mem_wa;
	logic [ROW_W-1:0]  mem_wd;

	assign q_idx    = {q_rec.lead_six, q_rec.subscriber};
	assign s2_idx   = {rec_s2.lead_six, rec_s2.subscriber};
	assign s2_row   = s2_idx[IDX_W-1:BSEL_W];
	assign s2_bit   = s2_idx[BSEL_W-1:0];
	assign old_row  = (fwd_valid_q && fwd_row_q == s2_row) ? fwd_data_q : rdata_s2;
	assign hit      = old_row[s2_bit];
	assign new_row  = old_row | (ROW_W'(1) << s2_bit);

	assign s2_fire  = s2_valid_q && (!out_valid_q || out_ready);
	assign s2_write = s2_fire && !rec_s2.bad && !hit;
	assign q_ready  = !clr_busy_q && (!s2_valid_q || s2_fire);
	assign load     = q_valid && q_ready;
	assign clr_done = !clr_busy_q;

	assign mem_we = clr_busy_q || s2_write;
	assign mem_wa = clr_busy_q ? clr_row_q : s2_row;
	assign mem_wd = clr_busy_q ? '0 : new_row;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			seen_mem[mem_wa] <= mem_wd;
		end
		if (load) begin
			rdata_s2 <= seen_mem[q_idx[IDX_W-1:BSEL_W]];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_s2     <= q_rec;
			fwd_row_q  <= s2_row;
			fwd_data_q <= new_row;
		end
		if (s2_fire) begin
			status_q <= rec_s2.bad ? ST_BAD : (hit ? ST_DUP : ST_NEW);
			prefix_q <= rec_s2.bad ? 1'b0 : rec_s2.lead_six;
			sub_q    <= rec_s2.bad ? '0 : rec_s2.subscriber;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q  <= 1'b1;
			clr_row_q   <= '0;
			s2_valid_q  <= 1'b0;
			fwd_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_row_q <= clr_row_q + 1'b1;
				if (clr_row_q == LAST_ROW) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (load) begin
				fwd_valid_q <= s2_write;
			end
			if (load) begin
				s2_valid_q <= 1'b1;
			end else if (s2_fire) begin
				s2_valid_q <= 1'b0;
			end
			if (s2_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign prefix_six = prefix_q;
	assign subscriber = sub_q;

`ifndef ASSERT_OFF
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> (!s2_valid_q && !out_valid_q))
		else $error("bitmap clear overlaps item traffic");

	a_clear_len: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_busy_q) |-> ($past(clr_row_q) == LAST_ROW))
		else $error("bitmap clear ended early");

	a_fwd_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(load && s2_write) |=> (fwd_valid_q && fwd_row_q == $past(s2_row)))
		else $error("write to bitmap not forwarded");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_BAD) |-> (sub_q == '0 && !prefix_q))
		else $error("invalid result carries a number");
`endif

endmodule
